### design/sqe_pkg.sv
package sqe_pkg;

  localparam int SQE_STORE_DEPTH = 64;

  localparam logic [2:0] CMD_PUSH  = 3'd0;
  localparam logic [2:0] CMD_PRINT = 3'd1;
  localparam logic [2:0] CMD_PEEK  = 3'd2;
  localparam logic [2:0] CMD_POP   = 3'd3;
  localparam logic [2:0] CMD_SWAP  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_value;
    logic               data_valid;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PEEK,
    S_PRINT,
    S_SWAP_A,
    S_SWAP_B,
    S_SWAP_C
  } ctl_state_t;

  typedef enum logic [1:0] {
    RD_TOP,
    RD_NEXT_TOP,
    RD_WALK,
    RD_WALK_NEXT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_PUSH,
    WR_SWAP_TOP,
    WR_SWAP_NEXT
  } wr_sel_t;

  typedef enum logic {
    OUT_STATUS,
    OUT_READ
  } out_sel_t;

  typedef struct packed {
    logic       pop;
    logic       walk_start;
    logic       walk_step;
    logic       save_tmp;
    rd_sel_t    rd_sel;
    wr_sel_t    wr_sel;
    logic       out_load;
    out_sel_t   out_sel;
    logic [1:0] out_status;
    logic       out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic short_store;
    logic walk_last;
    logic out_valid;
  } dp_stat_t;

endpackage

### design/sqe_ctl.sv
module sqe_ctl
  import sqe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] in_command,
  input  logic       out_ready,
  input  dp_stat_t   stat,
  output logic       in_ready,
  output dp_cmd_t    cmd
);

  ctl_state_t state;
  ctl_state_t state_next;
  logic       out_free;
  logic       take;

  assign out_free = !stat.out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (in_command)
            CMD_PRINT: if (!stat.empty) state_next = S_PRINT;
            CMD_PEEK:  if (!stat.empty) state_next = S_PEEK;
            CMD_SWAP:  if (!stat.short_store) state_next = S_SWAP_A;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_PEEK:   state_next = S_IDLE;
      S_PRINT:  if (out_free && stat.walk_last) state_next = S_IDLE;
      S_SWAP_A: state_next = S_SWAP_B;
      S_SWAP_B: state_next = S_SWAP_C;
      S_SWAP_C: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.pop        = 1'b0;
    cmd.walk_start = 1'b0;
    cmd.walk_step  = 1'b0;
    cmd.save_tmp   = 1'b0;
    cmd.rd_sel     = RD_TOP;
    cmd.wr_sel     = WR_NONE;
    cmd.out_load   = 1'b0;
    cmd.out_sel    = OUT_STATUS;
    cmd.out_status = ST_OK;
    cmd.out_last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (in_command)
            CMD_PUSH: begin
              cmd.out_load = 1'b1;
              if (stat.full) begin
                cmd.out_status = ST_FULL;
              end else begin
                cmd.wr_sel = WR_PUSH;
              end
            end
            CMD_PRINT: begin
              if (stat.empty) begin
                cmd.out_load = 1'b1;
              end else begin
                cmd.walk_start = 1'b1;
              end
            end
            CMD_PEEK: begin
              if (stat.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_EMPTY;
              end
            end
            CMD_POP: begin
              cmd.out_load = 1'b1;
              if (stat.empty) begin
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.pop = 1'b1;
              end
            end
            CMD_SWAP: begin
              if (stat.short_store) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_SHORT;
              end
            end
            default: cmd.out_load = 1'b1;
          endcase
        end
      end
      S_PEEK: begin
        cmd.out_load = 1'b1;
        cmd.out_sel  = OUT_READ;
      end
      S_PRINT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = OUT_READ;
          cmd.out_last  = stat.walk_last;
          cmd.walk_step = 1'b1;
          cmd.rd_sel    = RD_WALK_NEXT;
        end else begin
          cmd.rd_sel = RD_WALK;
        end
      end
      S_SWAP_A: begin
        cmd.save_tmp = 1'b1;
        cmd.rd_sel   = RD_NEXT_TOP;
      end
      S_SWAP_B: cmd.wr_sel = WR_SWAP_TOP;
      S_SWAP_C: begin
        cmd.wr_sel   = WR_SWAP_NEXT;
        cmd.out_load = 1'b1;
      end
      default: cmd.out_load = 1'b0;
    endcase
  end

endmodule

### design/sqe_dp.sv
module sqe_dp
  import sqe_pkg::*;
#(
  parameter int STORE_DEPTH = SQE_STORE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] push_value,
  input  logic               cfg_we,
  input  logic               cfg_data,
  input  logic               out_ready,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic               out_valid,
  output out_item_t          out_data
);

  localparam int PTR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(STORE_DEPTH - 1);
  localparam logic [CNT_W:0]   DEPTH_W  = (CNT_W + 1)'(STORE_DEPTH);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  logic signed [31:0] mem [STORE_DEPTH];
  logic [PTR_W-1:0]   top;
  logic [CNT_W-1:0]   count;
  logic               queue_mode;
  logic [PTR_W-1:0]   walk_ptr;
  logic [CNT_W-1:0]   walk_cnt;
  logic signed [31:0] tmp;
  logic signed [31:0] rdata;

  logic [PTR_W-1:0]   top_prev;
  logic [PTR_W-1:0]   top_nxt;
  logic [CNT_W:0]     tail_sum;
  logic [CNT_W:0]     tail_wrap;
  logic [PTR_W-1:0]   rd_addr;
  logic [PTR_W-1:0]   wr_addr;
  logic signed [31:0] wr_value;
  logic               wr_en;

  assign top_prev  = ring_prev(top);
  assign top_nxt   = ring_next(top);
  assign tail_sum  = {{(CNT_W + 1 - PTR_W){1'b0}}, top} + {1'b0, count};
  assign tail_wrap = (tail_sum >= DEPTH_W) ? tail_sum - DEPTH_W : tail_sum;

  assign stat.empty       = (count == '0);
  assign stat.full        = (count == CNT_W'(STORE_DEPTH));
  assign stat.short_store = (count < CNT_W'(2));
  assign stat.walk_last   = (walk_cnt == CNT_W'(1));
  assign stat.out_valid   = out_valid;

  always_comb begin
    case (cmd.rd_sel)
      RD_TOP:       rd_addr = top;
      RD_NEXT_TOP:  rd_addr = top_nxt;
      RD_WALK:      rd_addr = walk_ptr;
      RD_WALK_NEXT: rd_addr = ring_next(walk_ptr);
      default:      rd_addr = top;
    endcase
  end

  always_comb begin
    wr_en    = 1'b1;
    wr_addr  = top;
    wr_value = rdata;
    case (cmd.wr_sel)
      WR_PUSH: begin
        wr_addr  = queue_mode ? tail_wrap[PTR_W-1:0] : top_prev;
        wr_value = push_value;
      end
      WR_SWAP_TOP: begin
        wr_addr  = top;
        wr_value = rdata;
      end
      WR_SWAP_NEXT: begin
        wr_addr  = top_nxt;
        wr_value = tmp;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_value;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top        <= '0;
      count      <= '0;
      queue_mode <= 1'b0;
    end else begin
      if (cfg_we) begin
        queue_mode <= cfg_data;
      end
      if (cmd.wr_sel == WR_PUSH) begin
        if (!queue_mode) begin
          top <= top_prev;
        end
        count <= count + 1'b1;
      end else if (cmd.pop) begin
        top   <= top_nxt;
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      walk_ptr <= top;
      walk_cnt <= count;
    end else if (cmd.walk_step) begin
      walk_ptr <= ring_next(walk_ptr);
      walk_cnt <= walk_cnt - 1'b1;
    end
    if (cmd.save_tmp) begin
      tmp <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_sel == OUT_READ) begin
        out_data.status     <= ST_OK;
        out_data.data_value <= rdata;
        out_data.data_valid <= 1'b1;
        out_data.last       <= cmd.out_last;
      end else begin
        out_data.status     <= cmd.out_status;
        out_data.data_value <= '0;
        out_data.data_valid <= 1'b0;
        out_data.last       <= 1'b1;
      end
    end
  end

endmodule

### design/stack_queue_opcode_engine.sv
// Channel  | Signals                         | Moves
// ---------+---------------------------------+-----------------------------------
// in       | in_valid, in_ready, in_data     | one command transaction
// out      | out_valid, out_ready, out_data  | one result transaction
// cfg      | cfg_valid, cfg_ready, cfg_data  | queue_mode write (always ready)
//
// Push, pop, unused codes and every error load the result into the output
// register at the accept edge. Peek reads the top, then loads it. Swap saves
// the top, copies the next entry over it, then puts the saved value in next,
// set by the single read and write port. Print all emits each stored value,
// holding while out_ready is low. Commands are worked one at a time; in_ready
// also needs a free output slot. Reset (rst, synchronous) empties the store and
// clears queue_mode; no clearing pass is needed: only live entries are ever read.
module stack_queue_opcode_engine
  import sqe_pkg::*;
#(
  parameter int STORE_DEPTH = SQE_STORE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The user must issue configuration writes only while idle; the block does not enforce this and takes them at once.
  assign cfg_ready = 1'b1;

  // Controller: sequences each command and decides when the result loads.
  sqe_ctl u_ctl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .out_ready  (out_ready),
    .stat       (stat),
    .in_ready   (in_ready),
    .cmd        (cmd)
  );

  // Datapath: ring store, top/count pointers, print walker, output register.
  sqe_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .push_value (in_data.push_value),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

`ifndef SYNTH
  // Never overwrite a result that has not been delivered.
  a_load_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an undelivered result");

  // A push transaction always yields its result in the next cycle.
  a_push_answers: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.command == CMD_PUSH) |=> out_valid)
    else $error("push produced no result");

  // Each step of the print walk emits exactly one result.
  a_walk_emits: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step |-> (cmd.out_load && cmd.out_sel == OUT_READ))
    else $error("print walk advanced without a result");
`endif

endmodule
